### src/i2cm_pkg.sv
// package for the i2c master transaction engine: types, codes and constants
`default_nettype none
package i2cm_pkg;

  localparam int unsigned DelayWidthDef = 16;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] ByteMsb = 8'h80;
  localparam logic [7:0] ByteMax = 8'hFF;

  localparam logic [6:0]  SlaveAddrRst = 7'd0;
  localparam logic [15:0] HalfPeriodRst = 16'd50;
  localparam logic [15:0] StopHoldRst   = 16'd20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSlaveAddr  = 2'd0,
    CfgHalfPeriod = 2'd1,
    CfgStopHold   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqWrite = 2'd1,
    ReqRead  = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    PhIdle      = 4'd0,
    PhStartSda  = 4'd1,
    PhStartScl  = 4'd2,
    PhBitRise   = 4'd3,
    PhBitHigh   = 4'd4,
    PhBitLow    = 4'd5,
    PhAckRise   = 4'd6,
    PhAckHigh   = 4'd7,
    PhAckLow    = 4'd8,
    PhStopPrep  = 4'd9,
    PhStopRise  = 4'd10,
    PhStopHold  = 4'd11,
    PhFailHold  = 4'd12
  } phase_e;

  typedef struct packed {
    logic [6:0]  target_addr;
    logic [15:0] half_period_ticks;
    logic [15:0] stop_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       scl_in;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] byte_index;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } res_t;

endpackage
`default_nettype wire

### src/i2cm_cfg_regs.sv
// configuration registers of the i2c master
`default_nettype none
module i2cm_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [i2cm_pkg::CfgDataW-1:0]   cfg_data_i,
  output i2cm_pkg::cfg_t                       cfg_o
);

  i2cm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (i2cm_pkg::cfg_idx_e'(cfg_index_i))
        i2cm_pkg::CfgSlaveAddr:  cfg_d.target_addr       = cfg_data_i[6:0];
        i2cm_pkg::CfgHalfPeriod: cfg_d.half_period_ticks = cfg_data_i;
        i2cm_pkg::CfgStopHold:   cfg_d.stop_hold_ticks   = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_addr       <= i2cm_pkg::SlaveAddrRst;
      cfg_q.half_period_ticks <= i2cm_pkg::HalfPeriodRst;
      cfg_q.stop_hold_ticks   <= i2cm_pkg::StopHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### src/i2cm_seq.sv
// bus sequencer: state registers and one-tick next-state logic
`default_nettype none
module i2cm_seq #(
  parameter int unsigned DELAY_WIDTH = i2cm_pkg::DelayWidthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  i2cm_pkg::tick_t     tick_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  output i2cm_pkg::res_t      res_o
);

  localparam logic [32:0] WaitTop = (33'd1 << DELAY_WIDTH) - 33'd1;

  function automatic logic [DELAY_WIDTH-1:0] sat_wait(input logic [15:0] v);
    logic [32:0] ext;
    ext = {17'd0, v};
    if (ext == 33'd0) ext = 33'd1;
    if (ext > WaitTop) ext = WaitTop;
    return ext[DELAY_WIDTH-1:0];
  endfunction

  i2cm_pkg::phase_e       phase_q, phase_d;
  logic [3:0]             bit_cnt_q, bit_cnt_d;
  logic [7:0]             shift_q, shift_d;
  logic [7:0]             byte_pos_q, byte_pos_d;
  logic [7:0]             bytes_total_q, bytes_total_d;
  logic [DELAY_WIDTH-1:0] wait_q, wait_d;
  logic                   read_mode_q, read_mode_d;
  logic                   addr_stage_q, addr_stage_d;
  logic                   scl_drive_q, scl_drive_d;
  logic                   sda_drive_q, sda_drive_d;

  logic                   wait_over;
  logic                   sending;
  logic [DELAY_WIDTH-1:0] load_half, load_stop;
  logic [3:0]             cnt_inc;
  logic [7:0]             new_shift;
  logic                   last_byte;
  logic                   done, succ, rxv, rxl;
  logic [7:0]             rxb;

  assign wait_over = (wait_q <= DELAY_WIDTH'(1));
  assign sending   = !read_mode_q || addr_stage_q;
  assign load_half = sat_wait(cfg_i.half_period_ticks);
  assign load_stop = sat_wait(cfg_i.stop_hold_ticks);
  assign cnt_inc   = bit_cnt_q + 4'd1;
  assign last_byte = ({1'b0, byte_pos_q} + 9'd1) >= {1'b0, bytes_total_q};

  always_comb begin
    phase_d       = phase_q;
    bit_cnt_d     = bit_cnt_q;
    shift_d       = shift_q;
    byte_pos_d    = byte_pos_q;
    bytes_total_d = bytes_total_q;
    wait_d        = wait_q;
    read_mode_d   = read_mode_q;
    addr_stage_d  = addr_stage_q;
    scl_drive_d   = scl_drive_q;
    sda_drive_d   = sda_drive_q;
    new_shift     = shift_q;
    done          = 1'b0;
    succ          = 1'b0;
    rxv           = 1'b0;
    rxb           = 8'd0;
    rxl           = 1'b0;
    unique case (phase_q)
      i2cm_pkg::PhIdle: begin
        if (tick_i.req_type == i2cm_pkg::ReqWrite || tick_i.req_type == i2cm_pkg::ReqRead) begin
          read_mode_d   = (tick_i.req_type == i2cm_pkg::ReqRead);
          bytes_total_d = tick_i.byte_count;
          byte_pos_d    = 8'd0;
          addr_stage_d  = 1'b1;
          sda_drive_d   = 1'b1;
          scl_drive_d   = 1'b0;
          wait_d        = load_half;
          phase_d       = i2cm_pkg::PhStartSda;
        end
      end
      i2cm_pkg::PhStartSda: begin
        if (wait_over) begin
          scl_drive_d = 1'b1;
          wait_d      = load_half;
          phase_d     = i2cm_pkg::PhStartScl;
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhStartScl: begin
        if (wait_over) begin
          new_shift   = {cfg_i.target_addr, read_mode_q};
          shift_d     = new_shift;
          bit_cnt_d   = 4'd0;
          sda_drive_d = sending && ((new_shift & i2cm_pkg::ByteMsb) == 8'd0);
          scl_drive_d = 1'b0;
          phase_d     = i2cm_pkg::PhBitRise;
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhBitRise: begin
        if (tick_i.scl_in) begin
          if (!sending) shift_d = {shift_q[6:0], tick_i.sda_in};
          wait_d  = load_half;
          phase_d = i2cm_pkg::PhBitHigh;
        end
      end
      i2cm_pkg::PhBitHigh: begin
        if (wait_over) begin
          scl_drive_d = 1'b1;
          if (sending) shift_d = {shift_q[6:0], 1'b0};
          wait_d  = load_half;
          phase_d = i2cm_pkg::PhBitLow;
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhBitLow: begin
        if (wait_over) begin
          bit_cnt_d   = cnt_inc;
          scl_drive_d = 1'b0;
          if (cnt_inc < 4'd8) begin
            sda_drive_d = sending && ((shift_q & i2cm_pkg::ByteMsb) == 8'd0);
            phase_d     = i2cm_pkg::PhBitRise;
          end else begin
            if (sending) begin
              sda_drive_d = 1'b0;
            end else begin
              rxv         = 1'b1;
              rxb         = shift_q;
              rxl         = last_byte;
              sda_drive_d = !last_byte;
            end
            phase_d = i2cm_pkg::PhAckRise;
          end
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhAckRise: begin
        if (tick_i.scl_in) begin
          if (sending && tick_i.sda_in) begin
            sda_drive_d = 1'b0;
            wait_d      = load_stop;
            phase_d     = i2cm_pkg::PhFailHold;
          end else begin
            wait_d  = load_half;
            phase_d = i2cm_pkg::PhAckHigh;
          end
        end
      end
      i2cm_pkg::PhAckHigh: begin
        if (wait_over) begin
          scl_drive_d = 1'b1;
          sda_drive_d = !read_mode_q;
          if (!addr_stage_q && byte_pos_q != i2cm_pkg::ByteMax) byte_pos_d = byte_pos_q + 8'd1;
          wait_d  = load_half;
          phase_d = i2cm_pkg::PhAckLow;
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhAckLow: begin
        if (wait_over) begin
          addr_stage_d = 1'b0;
          if (byte_pos_q < bytes_total_q) begin
            new_shift   = read_mode_q ? shift_q : tick_i.tx_byte;
            shift_d     = new_shift;
            bit_cnt_d   = 4'd0;
            sda_drive_d = !read_mode_q && ((new_shift & i2cm_pkg::ByteMsb) == 8'd0);
            scl_drive_d = 1'b0;
            phase_d     = i2cm_pkg::PhBitRise;
          end else begin
            sda_drive_d = 1'b1;
            wait_d      = load_half;
            phase_d     = i2cm_pkg::PhStopPrep;
          end
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhStopPrep: begin
        if (wait_over) begin
          scl_drive_d = 1'b0;
          phase_d     = i2cm_pkg::PhStopRise;
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      i2cm_pkg::PhStopRise: begin
        if (tick_i.scl_in) begin
          wait_d  = load_stop;
          phase_d = i2cm_pkg::PhStopHold;
        end
      end
      i2cm_pkg::PhStopHold, i2cm_pkg::PhFailHold: begin
        if (wait_over) begin
          sda_drive_d = 1'b0;
          scl_drive_d = 1'b0;
          done        = 1'b1;
          succ        = (phase_q == i2cm_pkg::PhStopHold);
          phase_d     = i2cm_pkg::PhIdle;
        end else begin
          wait_d = wait_q - DELAY_WIDTH'(1);
        end
      end
      default: begin
        phase_d     = i2cm_pkg::PhIdle;
        scl_drive_d = 1'b0;
        sda_drive_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.scl_low    = scl_drive_d;
    res_o.sda_low    = sda_drive_d;
    res_o.busy_res   = (phase_d != i2cm_pkg::PhIdle);
    res_o.done_res   = done;
    res_o.success    = succ;
    res_o.byte_index = byte_pos_d;
    res_o.rx_valid   = rxv;
    res_o.rx_byte    = rxb;
    res_o.rx_last    = rxl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= i2cm_pkg::PhIdle;
      bit_cnt_q     <= 4'd0;
      shift_q       <= 8'd0;
      byte_pos_q    <= 8'd0;
      bytes_total_q <= 8'd0;
      wait_q        <= '0;
      read_mode_q   <= 1'b0;
      addr_stage_q  <= 1'b0;
      scl_drive_q   <= 1'b0;
      sda_drive_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q       <= phase_d;
      bit_cnt_q     <= bit_cnt_d;
      shift_q       <= shift_d;
      byte_pos_q    <= byte_pos_d;
      bytes_total_q <= bytes_total_d;
      wait_q        <= wait_d;
      read_mode_q   <= read_mode_d;
      addr_stage_q  <= addr_stage_d;
      scl_drive_q   <= scl_drive_d;
      sda_drive_q   <= sda_drive_d;
    end
  end

endmodule
`default_nettype wire

### src/i2c_master_transaction_engine.sv
// top level of the i2c master transaction engine
//
// every input beat is one timing tick of an open-drain i2c master. tuser
// carries the request kind (tick, start write, start read); a start request
// taken while idle runs a full transaction: start, address byte with r/w,
// data bytes msb first, each with its ack clock, then stop. tx_byte is sampled
// when a data byte begins, at the byte index shown on the previous result.
// each input beat yields exactly one result beat holding the line drives,
// busy, done/success and any received byte (tuser = rx valid, tlast = last
// byte of a read). scl releases wait for scl_in high, so stretching works.
// the result beat is registered and appears in the cycle after its input
// beat is accepted; throughput is one beat per cycle unless the receiver
// stalls, set by the combinational sequencer step between the state and
// result registers. when the receiver stalls, the result register holds
// and input is accepted again as soon as that result is taken.
// reset (async, active low) returns to idle with both lines released and
// restores the register defaults: address 0, half period 50, stop hold 20.
// configuration writes are taken every cycle on the cfg channel.
`default_nettype none
module i2c_master_transaction_engine #(
  parameter int unsigned DELAY_WIDTH = i2cm_pkg::DelayWidthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // byte_count, tx_byte, scl_in, sda_in, zero pad
  input  wire logic [i2cm_pkg::InDataW-1:0]     s_axis_tdata_i,
  // req_type
  input  wire logic [1:0]                       s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // scl_low, sda_low, busy_res, done_res, success, byte_index, rx_byte, zero pad
  output logic [i2cm_pkg::OutDataW-1:0]         m_axis_tdata_o,
  // rx_valid
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tlast_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [i2cm_pkg::CfgDataW-1:0]    cfg_data_i
);

  i2cm_pkg::cfg_t  cfg;
  i2cm_pkg::tick_t tick;
  i2cm_pkg::res_t  res_d, res_q;
  logic            out_valid_q;
  logic            accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign tick.req_type   = s_axis_tuser_i;
  assign tick.byte_count = s_axis_tdata_i[7:0];
  assign tick.tx_byte    = s_axis_tdata_i[15:8];
  assign tick.scl_in     = s_axis_tdata_i[16];
  assign tick.sda_in     = s_axis_tdata_i[17];

  i2cm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cm_seq #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .tick_i (tick),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, res_q.rx_byte, res_q.byte_index, res_q.success,
                            res_q.done_res, res_q.busy_res, res_q.sda_low, res_q.scl_low};
  assign m_axis_tuser_o  = res_q.rx_valid;
  assign m_axis_tlast_o  = res_q.rx_last;

  // a finished transaction is no longer busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_q.done_res |-> !res_q.busy_res)
    else $error("done reported while still busy");

  // last-byte flag only with a received byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("rx_last without rx_valid");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // every accepted tick shows a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

endmodule
`default_nettype wire
